>>> rtl/s2ok_pkg.sv
package s2ok_pkg;

   localparam int ChanBits = 8;
   localparam int CodeMax = (1 << ChanBits) - 1;
   localparam int LinBits = 16;
   localparam int FracBits = 15;
   localparam int LmsBits = 32;
   localparam int CrBits = 31;
   localparam int CoefBits = 18;
   localparam int CrSteps = 31;
   localparam longint TenE10 = 64'sd10000000000;
   localparam longint unsigned Q30One = 64'd1 << 30;
   localparam longint unsigned TenE10Half = longint'(TenE10 / 2);
   localparam longint unsigned LinHalf = 1292 * CodeMax;
   localparam longint unsigned LinDen = 2 * 1292 * CodeMax;
   localparam longint unsigned CurveHalf = (1055 * CodeMax) / 2;
   localparam longint unsigned CurveDen = 1055 * CodeMax;

   typedef struct packed {
      logic       valid;
      logic [7:0] alpha;
   } tag_type;

   typedef logic [LinBits-1:0] lin_table_type [256];

   function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   // Restoring division, used only while the constant tables are built.
   function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int bt = 63; bt >= 0; bt--) begin
         r = (r << 1) | ((n >> bt) & 64'd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'd1 << bt);
         end
      end
      return q;
   endfunction

   function automatic longint unsigned fifth_root(longint unsigned u);
      longint unsigned r;
      longint unsigned c;
      longint unsigned p;
      r = 0;
      if (u >= Q30One) begin
         return Q30One;
      end
      for (int bt = 29; bt >= 0; bt--) begin
         c = r | (64'd1 << bt);
         p = mul30(mul30(mul30(mul30(c, c), c), c), c);
         if (p <= u) begin
            r = c;
         end
      end
      return r;
   endfunction

   // The sRGB decode curve, evaluated once at elaboration.
   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      longint unsigned c;
      longint unsigned t;
      longint unsigned u;
      longint unsigned w;
      longint unsigned v;
      for (int code = 0; code < 256; code++) begin
         c = longint'(code) & longint'(CodeMax);
         if (c * 100000 <= 4045 * CodeMax) begin
            tbl[code] = LinBits'(udiv(c * 65535 * 200 + LinHalf, LinDen));
         end else begin
            t = udiv(((1000 * c + 55 * CodeMax) << 30) + CurveHalf, CurveDen);
            u = (t * t + (Q30One >> 1)) >> 30;
            w = fifth_root(u);
            v = mul30(u, w);
            tbl[code] = LinBits'((v * 65535 + (Q30One >> 1)) >> 30);
         end
      end
      return tbl;
   endfunction

   function automatic longint coef_q(longint k);
      longint unsigned mag;
      longint unsigned q;
      mag = (k < 0) ? longint'(-k) : longint'(k);
      q = udiv((mag << FracBits) + TenE10Half, longint'(TenE10));
      return (k < 0) ? -longint'(q) : longint'(q);
   endfunction

   localparam lin_table_type LinTable = build_lin_table();

   localparam logic [LinBits-1:0] LmsCoef [3][3] = '{
      '{LinBits'(coef_q(64'sd4122214708)), LinBits'(coef_q(64'sd5363325363)),
        LinBits'(coef_q(64'sd514459929))},
      '{LinBits'(coef_q(64'sd2119034982)), LinBits'(coef_q(64'sd6806995451)),
        LinBits'(coef_q(64'sd1073969566))},
      '{LinBits'(coef_q(64'sd883024619)), LinBits'(coef_q(64'sd2817188376)),
        LinBits'(coef_q(64'sd6299787005))}
   };

   localparam logic signed [CoefBits-1:0] LabCoef [3][3] = '{
      '{CoefBits'(coef_q(64'sd2104542553)), CoefBits'(coef_q(64'sd7936177850)),
        CoefBits'(coef_q(-64'sd40720468))},
      '{CoefBits'(coef_q(64'sd19779984951)), CoefBits'(coef_q(-64'sd24285922050)),
        CoefBits'(coef_q(64'sd4505937099))},
      '{CoefBits'(coef_q(64'sd259040371)), CoefBits'(coef_q(64'sd7827717662)),
        CoefBits'(coef_q(-64'sd8086757660))}
   };

endpackage

>>> rtl/s2ok_lms.sv
module s2ok_lms (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  s2ok_pkg::tag_type                    in_tag,
   input  logic [7:0]                           red,
   input  logic [7:0]                           green,
   input  logic [7:0]                           blue,
   output s2ok_pkg::tag_type                    out_tag,
   output logic [2:0][s2ok_pkg::LmsBits-1:0]    lms
);

   s2ok_pkg::tag_type                       tag_ff [6];
   logic [2:0][s2ok_pkg::LinBits-1:0]       lin_ff;
   logic [31:0]                             prod_ff [3][3];
   logic [49:0]                             num_ff [3];
   logic [49:0]                             numq_ff [3];
   logic [33:0]                             quot_ff [3];
   logic [33:0]                             quotr_ff [3];
   logic [19:0]                             rem_ff [3];
   logic [2:0][s2ok_pkg::LmsBits-1:0]       lms_ff;
   logic [7:0]                              code [3];

   assign code[0] = red;
   assign code[1] = green;
   assign code[2] = blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 6; s++) begin
            tag_ff[s] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < 6; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   // Division by 65535 uses the geometric series of 2^-16 and a small correction.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            lin_ff[i] <= s2ok_pkg::LinTable[code[i]];
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= 32'(s2ok_pkg::LmsCoef[i][j]) * 32'(lin_ff[j]);
            end
            num_ff[i] <= ({16'd0, 34'(prod_ff[i][0]) + 34'(prod_ff[i][1]) + 34'(prod_ff[i][2])}
                          << 15) + 50'd32767;
            quot_ff[i] <= 34'(num_ff[i] >> 16) + 34'(num_ff[i] >> 32) + 34'(num_ff[i] >> 48);
            numq_ff[i] <= num_ff[i];
            rem_ff[i] <= 20'(numq_ff[i] - ({16'd0, quot_ff[i]} << 16) + {16'd0, quot_ff[i]});
            quotr_ff[i] <= quot_ff[i];
            lms_ff[i] <= s2ok_pkg::LmsBits'(quotr_ff[i]
                         + 34'(rem_ff[i] >= 20'd65535) + 34'(rem_ff[i] >= 20'd131070)
                         + 34'(rem_ff[i] >= 20'd196605) + 34'(rem_ff[i] >= 20'd262140));
         end
      end
   end

   assign out_tag = tag_ff[5];
   assign lms = lms_ff;

endmodule

>>> rtl/s2ok_cbrt.sv
module s2ok_cbrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  s2ok_pkg::tag_type                    in_tag,
   input  logic [2:0][s2ok_pkg::LmsBits-1:0]    lms,
   output s2ok_pkg::tag_type                    out_tag,
   output logic [2:0][s2ok_pkg::CrBits-1:0]     root
);

   localparam int N = s2ok_pkg::CrSteps;

   s2ok_pkg::tag_type                 taga_ff [N];
   s2ok_pkg::tag_type                 tagb_ff [N];
   logic [s2ok_pkg::CrBits-1:0]       ca_ff [N][3];
   logic [63:0]                       c2a_ff [N][3];
   logic [62:0]                       pa_ff [N][3];
   logic [s2ok_pkg::CrBits-1:0]       ra_ff [N][3];
   logic [63:0]                       r2a_ff [N][3];
   logic [s2ok_pkg::LmsBits-1:0]      xa_ff [N][3];
   logic [s2ok_pkg::CrBits-1:0]       rb_ff [N][3];
   logic [63:0]                       r2b_ff [N][3];
   logic [s2ok_pkg::LmsBits-1:0]      xb_ff [N][3];

   // Each bit of the root takes two stages: square and multiply, then compare.
   for (genvar i = 0; i < N; i++) begin : g_bit
      localparam int B = N - 1 - i;
      s2ok_pkg::tag_type               tag_prev;
      logic [s2ok_pkg::CrBits-1:0]     r_prev [3];
      logic [63:0]                     r2_prev [3];
      logic [s2ok_pkg::LmsBits-1:0]    x_prev [3];
      logic [s2ok_pkg::CrBits-1:0]     c [3];
      logic [63:0]                     c2 [3];
      logic [62:0]                     p [3];

      for (genvar k = 0; k < 3; k++) begin : g_lane
         if (i == 0) begin : g_first
            assign r_prev[k] = '0;
            assign r2_prev[k] = '0;
            assign x_prev[k] = lms[k];
         end else begin : g_next
            assign r_prev[k] = rb_ff[i-1][k];
            assign r2_prev[k] = r2b_ff[i-1][k];
            assign x_prev[k] = xb_ff[i-1][k];
         end
         assign c[k] = r_prev[k] | (s2ok_pkg::CrBits'(1) << B);
         assign c2[k] = r2_prev[k] + ({33'd0, r_prev[k]} << (B + 1)) + (64'd1 << (2 * B));
         assign p[k] = 63'(c2[k][61:30]) * 63'(c[k]);
      end

      if (i == 0) begin : g_tag_first
         assign tag_prev = in_tag;
      end else begin : g_tag_next
         assign tag_prev = tagb_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            taga_ff[i] <= '0;
            tagb_ff[i] <= '0;
         end else if (en) begin
            taga_ff[i] <= tag_prev;
            tagb_ff[i] <= taga_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int k = 0; k < 3; k++) begin
               ca_ff[i][k] <= c[k];
               c2a_ff[i][k] <= c2[k];
               pa_ff[i][k] <= p[k];
               ra_ff[i][k] <= r_prev[k];
               r2a_ff[i][k] <= r2_prev[k];
               xa_ff[i][k] <= x_prev[k];
               xb_ff[i][k] <= xa_ff[i][k];
               if (pa_ff[i][k][62:30] <= {1'b0, xa_ff[i][k]}) begin
                  rb_ff[i][k] <= ca_ff[i][k];
                  r2b_ff[i][k] <= c2a_ff[i][k];
               end else begin
                  rb_ff[i][k] <= ra_ff[i][k];
                  r2b_ff[i][k] <= r2a_ff[i][k];
               end
            end
         end
      end
   end

   assign out_tag = tagb_ff[N-1];
   for (genvar k = 0; k < 3; k++) begin : g_out
      assign root[k] = rb_ff[N-1][k];
   end

endmodule

>>> rtl/s2ok_lab.sv
module s2ok_lab (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  s2ok_pkg::tag_type                    in_tag,
   input  logic [2:0][s2ok_pkg::CrBits-1:0]     root,
   output s2ok_pkg::tag_type                    out_tag,
   output logic [15:0]                          lightness,
   output logic [15:0]                          green_red_axis,
   output logic [15:0]                          blue_yellow_axis
);

   s2ok_pkg::tag_type     tag_ff [4];
   logic signed [49:0]    prod_ff [3][3];
   logic signed [51:0]    sum_ff [3];
   logic                  neg_ff [3];
   logic [21:0]           mag_ff [3];
   logic [15:0]           res_ff [3];
   logic [51:0]           abs_v [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) begin
            tag_ff[s] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < 4; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = sum_ff[i][51] ? 52'(-sum_ff[i]) : 52'(sum_ff[i]);
      end
   end

   // Rounding is half away from zero, then each axis saturates to its range.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= 50'(s2ok_pkg::LabCoef[i][j]) * 50'($signed({1'b0, root[j]}));
            end
            sum_ff[i] <= 52'(prod_ff[i][0]) + 52'(prod_ff[i][1]) + 52'(prod_ff[i][2]);
            neg_ff[i] <= sum_ff[i][51];
            mag_ff[i] <= 22'((abs_v[i] + 52'd536870912) >> 30);
         end
         if (neg_ff[0]) begin
            res_ff[0] <= '0;
         end else if (mag_ff[0] > 22'd32768) begin
            res_ff[0] <= 16'd32768;
         end else begin
            res_ff[0] <= mag_ff[0][15:0];
         end
         for (int i = 1; i < 3; i++) begin
            if (neg_ff[i]) begin
               res_ff[i] <= (mag_ff[i] > 22'd32768) ? 16'h8000 : 16'(-mag_ff[i]);
            end else begin
               res_ff[i] <= (mag_ff[i] > 22'd32767) ? 16'h7fff : mag_ff[i][15:0];
            end
         end
      end
   end

   assign out_tag = tag_ff[3];
   assign lightness = res_ff[0];
   assign green_red_axis = res_ff[1];
   assign blue_yellow_axis = res_ff[2];

endmodule

>>> rtl/srgb_to_oklab_convert.sv
// Converts one sRGB pixel with alpha to OkLab in every clock cycle. The path is a
// 72-stage pipeline: 6 stages decode the codes through a 256-entry linear-light table
// and form the LMS responses, 62 stages take the bit-by-bit cube roots (two per root
// bit, 31 bits), and 4 stages apply the Lab matrix, round and saturate. The result
// register is the last stage; a stall on the result side freezes the whole pipeline,
// so a beat is accepted in every cycle in which no finished result is held back.

module srgb_to_oklab_convert (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_red_in,
   input  logic [7:0]    req_green_in,
   input  logic [7:0]    req_blue_in,
   input  logic [7:0]    req_alpha_in,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_lightness,
   output logic [15:0]   rsp_green_red_axis,
   output logic [15:0]   rsp_blue_yellow_axis,
   output logic [7:0]    rsp_alpha_out
);

   logic                                    en;
   s2ok_pkg::tag_type                       in_tag;
   s2ok_pkg::tag_type                       lms_tag;
   s2ok_pkg::tag_type                       cr_tag;
   s2ok_pkg::tag_type                       out_tag;
   logic [2:0][s2ok_pkg::LmsBits-1:0]       lms;
   logic [2:0][s2ok_pkg::CrBits-1:0]        root;

   assign en = !out_tag.valid || rsp_ready;
   assign req_ready = en;
   assign in_tag.valid = req_valid;
   assign in_tag.alpha = req_alpha_in;

   s2ok_lms u_lms (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (in_tag),
      .red     (req_red_in),
      .green   (req_green_in),
      .blue    (req_blue_in),
      .out_tag (lms_tag),
      .lms     (lms)
   );

   s2ok_cbrt u_cbrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (lms_tag),
      .lms     (lms),
      .out_tag (cr_tag),
      .root    (root)
   );

   s2ok_lab u_lab (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_tag           (cr_tag),
      .root             (root),
      .out_tag          (out_tag),
      .lightness        (rsp_lightness),
      .green_red_axis   (rsp_green_red_axis),
      .blue_yellow_axis (rsp_blue_yellow_axis)
   );

   assign rsp_valid = out_tag.valid;
   assign rsp_alpha_out = out_tag.alpha;

endmodule
